### rtl/hcv_pkg.sv
`default_nettype none
package hcv_pkg;

   localparam int unsigned DEF_MAX_WIDTH   = 256;
   localparam int unsigned DEF_MAX_HEIGHT  = 256;
   localparam int unsigned DEF_MAX_RADII   = 32;
   localparam int unsigned DEF_ANGLE_STEPS = 360;

   localparam int unsigned COUNT_W = 16;
   localparam int unsigned CSR_AW  = 5;
   localparam int unsigned CSR_DW  = 32;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint Q30_ONE     = 64'sd1073741824;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_RADIUS_MIN   = 3'd2,
      REG_RADIUS_MAX   = 3'd3,
      REG_RADIUS_STEP  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_VOTE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VOTE,
      ST_DRAIN,
      ST_READ,
      ST_RWAIT
   } state_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] pixel_value;
      logic [4:0] radius_index;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] vote_count;
   } rsp_payload_type;

   // Q30 product, used at elaboration only
   function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic logic signed [15:0] q30_to_q14(longint v);
      longint unsigned mag;
      longint unsigned r;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      r   = (mag + 64'd32768) >> 16;
      if (r > 64'd16384) begin
         r = 64'd16384;
      end
      return (v < 0) ? -16'(r) : 16'(r);
   endfunction

   // fold a first-quadrant sine and cosine into the full circle
   function automatic logic signed [15:0] quad_q14(logic [1:0] quad, longint s, longint c,
                                                   bit want_sin);
      longint sv;
      longint cv;
      unique case (quad)
         2'd0: begin sv = s;  cv = c;  end
         2'd1: begin sv = c;  cv = -s; end
         2'd2: begin sv = -s; cv = -c; end
         2'd3: begin sv = -c; cv = s;  end
      endcase
      return want_sin ? q30_to_q14(sv) : q30_to_q14(cv);
   endfunction

   // round(p / 2^14), half away from zero
   function automatic logic signed [9:0] round_q14(logic signed [24:0] p);
      logic [24:0] mag;
      logic [9:0]  q;
      mag = p[24] ? 25'(-p) : 25'(p);
      q   = 10'((mag + 25'd8192) >> 14);
      return p[24] ? $signed(-q) : $signed(q);
   endfunction

endpackage
`default_nettype wire

### rtl/hcv_req_if.sv
`default_nettype none
interface hcv_req_if;
   logic                     valid;
   logic                     ready;
   hcv_pkg::req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/hcv_rsp_if.sv
`default_nettype none
interface hcv_rsp_if;
   logic                     valid;
   logic                     ready;
   hcv_pkg::rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/hcv_ram.sv
`default_nettype none
module hcv_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

### rtl/hough_circle_voter.sv
`default_nettype none
// channel | dir | handshake        | beat contents
// req     | in  | valid/ready      | mode, pos_x, pos_y, pixel_value, radius_index
// rsp     | out | valid/ready      | vote_count (read commands only)
// csr     | in  | APB, pready high | image size and radius range registers
// A vote beat sweeps radii x ANGLE_STEPS angles, one accumulator update per cycle
// for each centre inside the image, then drains the update pipeline before idle.
// A read beat passes ST_READ, waiting there for a free result slot, and ST_RWAIT;
// a clear sweeps the whole store, one entry per cycle, as does the pass after reset.
// The accumulator store has one write and one read port; req is held off meanwhile.
module hough_circle_voter #(
   parameter int unsigned MAX_WIDTH   = hcv_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT  = hcv_pkg::DEF_MAX_HEIGHT,
   parameter int unsigned MAX_RADII   = hcv_pkg::DEF_MAX_RADII,
   parameter int unsigned ANGLE_STEPS = hcv_pkg::DEF_ANGLE_STEPS
) (
   input  wire                         clock,
   input  wire                         reset,
   hcv_req_if.sink                     req_chan,
   hcv_rsp_if.source                   rsp_chan,
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire [hcv_pkg::CSR_AW-1:0]   paddr,
   input  wire [hcv_pkg::CSR_DW-1:0]   pwdata,
   output logic [hcv_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import hcv_pkg::*;

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_RADII;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned KW    = $clog2(ANGLE_STEPS);
   localparam int unsigned IW    = $clog2(MAX_RADII + 1);

   // configuration
   logic [8:0] image_width_ff, image_height_ff;
   logic [7:0] radius_min_ff, radius_max_ff, radius_step_ff;
   reg_index_type csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 9'd256;
         image_height_ff <= 9'd256;
         radius_min_ff   <= 8'd70;
         radius_max_ff   <= 8'd90;
         radius_step_ff  <= 8'd1;
      end else if (psel && penable && pwrite) begin
         unique case (csr_idx)
            REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[8:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[8:0];
            REG_RADIUS_MIN:   radius_min_ff   <= pwdata[7:0];
            REG_RADIUS_MAX:   radius_max_ff   <= pwdata[7:0];
            REG_RADIUS_STEP:  radius_step_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_IMAGE_WIDTH:  prdata = CSR_DW'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DW'(image_height_ff);
         REG_RADIUS_MIN:   prdata = CSR_DW'(radius_min_ff);
         REG_RADIUS_MAX:   prdata = CSR_DW'(radius_max_ff);
         REG_RADIUS_STEP:  prdata = CSR_DW'(radius_step_ff);
         default:          prdata = '0;
      endcase
   end

   // sine and cosine tables, built at elaboration from a Q30 Taylor series
   logic signed [15:0] sin_tab [ANGLE_STEPS];
   logic signed [15:0] cos_tab [ANGLE_STEPS];
   for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_trig
      localparam longint M    = 4 * longint'(k);
      localparam longint QUAD = M / longint'(ANGLE_STEPS);
      localparam longint REM  = M % longint'(ANGLE_STEPS);
      localparam longint PHI  = HALF_PI_Q30 * REM / longint'(ANGLE_STEPS);
      localparam longint unsigned P2 = (PHI * PHI) >> 30;
      localparam longint unsigned S1 = q30_mul(PHI, P2) / 64'd6;
      localparam longint unsigned S2 = q30_mul(S1, P2) / 64'd20;
      localparam longint unsigned S3 = q30_mul(S2, P2) / 64'd42;
      localparam longint unsigned S4 = q30_mul(S3, P2) / 64'd72;
      localparam longint unsigned S5 = q30_mul(S4, P2) / 64'd110;
      localparam longint unsigned S6 = q30_mul(S5, P2) / 64'd156;
      localparam longint unsigned S7 = q30_mul(S6, P2) / 64'd210;
      localparam longint unsigned S8 = q30_mul(S7, P2) / 64'd272;
      localparam longint unsigned S9 = q30_mul(S8, P2) / 64'd342;
      localparam longint unsigned C1 = q30_mul(Q30_ONE, P2) / 64'd2;
      localparam longint unsigned C2 = q30_mul(C1, P2) / 64'd12;
      localparam longint unsigned C3 = q30_mul(C2, P2) / 64'd30;
      localparam longint unsigned C4 = q30_mul(C3, P2) / 64'd56;
      localparam longint unsigned C5 = q30_mul(C4, P2) / 64'd90;
      localparam longint unsigned C6 = q30_mul(C5, P2) / 64'd132;
      localparam longint unsigned C7 = q30_mul(C6, P2) / 64'd182;
      localparam longint unsigned C8 = q30_mul(C7, P2) / 64'd240;
      localparam longint unsigned C9 = q30_mul(C8, P2) / 64'd306;
      localparam longint SER_S = PHI - longint'(S1) + longint'(S2) - longint'(S3)
                                 + longint'(S4) - longint'(S5) + longint'(S6)
                                 - longint'(S7) + longint'(S8) - longint'(S9);
      localparam longint SER_C = Q30_ONE - longint'(C1) + longint'(C2) - longint'(C3)
                                 + longint'(C4) - longint'(C5) + longint'(C6)
                                 - longint'(C7) + longint'(C8) - longint'(C9);
      localparam logic signed [15:0] SIN_V = quad_q14(2'(QUAD), SER_S, SER_C, 1'b1);
      localparam logic signed [15:0] COS_V = quad_q14(2'(QUAD), SER_S, SER_C, 1'b0);
      assign sin_tab[k] = SIN_V;
      assign cos_tab[k] = COS_V;
   end

   // control
   state_type state_ff, state_in;
   logic [7:0] px_ff, py_ff;
   logic [4:0] ri_ff;
   logic [KW-1:0] k_ff, k_in;
   logic [IW-1:0] i_ff, i_in;
   logic [8:0] r_ff, r_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic emit;
   logic pipe_busy;
   logic req_take;
   logic slot_free;
   logic rd_hit_ff;

   // pipeline
   logic               t_v_ff;
   logic [IW-1:0]      t_i_ff;
   logic [8:0]         t_r_ff;
   logic signed [15:0] t_sin_ff, t_cos_ff;
   logic               m_v_ff;
   logic [IW-1:0]      m_i_ff;
   logic signed [24:0] m_ps_ff, m_pc_ff;
   logic               c_v_ff;
   logic [IW-1:0]      c_i_ff;
   logic [8:0]         c_cx_ff, c_cy_ff;
   logic               a_v_ff;
   logic [AW-1:0]      a_addr_ff;
   logic               w_v_ff;
   logic [AW-1:0]      w_addr_ff;
   logic [COUNT_W-1:0] w_data_ff;

   logic signed [10:0] cx_calc, cy_calc;
   logic               in_image;
   logic [AW-1:0]      vote_addr, read_addr;
   logic               read_ok;

   logic               ram_wr_en, ram_rd_en;
   logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [COUNT_W-1:0] ram_wr_data, ram_rd_data;
   logic [COUNT_W-1:0] old_count, new_count;

   logic               rsp_v_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   assign pipe_busy = t_v_ff || m_v_ff || c_v_ff || a_v_ff;
   assign slot_free = !rsp_v_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take = req_chan.valid && req_chan.ready;
   assign emit = (state_ff == ST_VOTE) && (r_ff < {1'b0, radius_max_ff})
                 && (int'(i_ff) < MAX_RADII);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      r_in     = r_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            k_in   = '0;
            i_in   = '0;
            r_in   = {1'b0, radius_min_ff};
            clr_in = '0;
            if (req_chan.valid) begin
               priority if (req_chan.data.mode == MODE_VOTE
                            && req_chan.data.pixel_value != 8'd0) begin
                  state_in = ST_VOTE;
               end else if (req_chan.data.mode == MODE_READ) begin
                  state_in = ST_READ;
               end else if (req_chan.data.mode == MODE_CLEAR) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_VOTE: begin
            if (emit) begin
               if (k_ff == KW'(ANGLE_STEPS - 1)) begin
                  k_in = '0;
                  i_in = i_ff + IW'(1);
                  r_in = r_ff + {1'b0, radius_step_ff};
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (slot_free) begin
               state_in = ST_RWAIT;
            end
         end
         ST_RWAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         r_ff     <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         px_ff <= req_chan.data.pos_x;
         py_ff <= req_chan.data.pos_y;
         ri_ff <= req_chan.data.radius_index;
      end
   end

   // stage: table lookup
   always_ff @(posedge clock) begin
      t_i_ff   <= i_ff;
      t_r_ff   <= r_ff;
      t_sin_ff <= sin_tab[k_ff];
      t_cos_ff <= cos_tab[k_ff];
   end

   // stage: products
   always_ff @(posedge clock) begin
      m_i_ff  <= t_i_ff;
      m_ps_ff <= $signed({1'b0, t_r_ff}) * t_sin_ff;
      m_pc_ff <= $signed({1'b0, t_r_ff}) * t_cos_ff;
   end

   // stage: round, centre and bounds
   assign cx_calc = $signed({3'b000, px_ff}) - 11'(round_q14(m_ps_ff));
   assign cy_calc = $signed({3'b000, py_ff}) - 11'(round_q14(m_pc_ff));
   assign in_image = !cx_calc[10] && !cy_calc[10]
                     && ({2'b00, cx_calc[9:0]} < {3'b000, image_width_ff})
                     && ({2'b00, cy_calc[9:0]} < {3'b000, image_height_ff})
                     && (int'(cx_calc[9:0]) < MAX_WIDTH)
                     && (int'(cy_calc[9:0]) < MAX_HEIGHT);

   always_ff @(posedge clock) begin
      c_i_ff  <= m_i_ff;
      c_cx_ff <= cx_calc[8:0];
      c_cy_ff <= cy_calc[8:0];
   end

   assign vote_addr = AW'((AW'(c_cy_ff) * AW'(MAX_WIDTH) + AW'(c_cx_ff)) * AW'(MAX_RADII)
                          + AW'(c_i_ff));
   assign read_addr = AW'((AW'(py_ff) * AW'(MAX_WIDTH) + AW'(px_ff)) * AW'(MAX_RADII)
                          + AW'(ri_ff));
   assign read_ok   = ({1'b0, px_ff} < image_width_ff) && ({1'b0, py_ff} < image_height_ff)
                      && (int'(px_ff) < MAX_WIDTH) && (int'(py_ff) < MAX_HEIGHT)
                      && (int'(ri_ff) < MAX_RADII);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
         w_v_ff <= 1'b0;
      end else begin
         t_v_ff <= emit;
         m_v_ff <= t_v_ff;
         c_v_ff <= m_v_ff && in_image;
         a_v_ff <= c_v_ff;
         w_v_ff <= a_v_ff;
      end
   end

   // stage: read back, forward the last write, saturating increment
   assign old_count = (w_v_ff && (w_addr_ff == a_addr_ff)) ? w_data_ff : ram_rd_data;
   assign new_count = (old_count == {COUNT_W{1'b1}}) ? old_count : old_count + COUNT_W'(1);

   always_ff @(posedge clock) begin
      a_addr_ff <= vote_addr;
      w_addr_ff <= a_addr_ff;
      w_data_ff <= new_count;
   end

   assign ram_rd_en   = c_v_ff || (state_ff == ST_READ);
   assign ram_rd_addr = c_v_ff ? vote_addr : read_addr;
   assign ram_wr_en   = a_v_ff || (state_ff == ST_CLEAR);
   assign ram_wr_addr = a_v_ff ? a_addr_ff : clr_ff;
   assign ram_wr_data = a_v_ff ? new_count : '0;

   hcv_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_acc (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_hit_ff <= read_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (state_ff == ST_RWAIT) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RWAIT) begin
         rsp_count_ff <= rd_hit_ff ? ram_rd_data : '0;
      end
   end

   assign rsp_chan.valid           = rsp_v_ff;
   assign rsp_chan.data.vote_count = rsp_count_ff;

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_VOTE || state_ff == ST_DRAIN || state_ff == ST_CLEAR))
      else $error("accumulator written outside a vote or clear");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && !a_v_ff) |-> (ram_wr_data == '0))
      else $error("clear sweep wrote a nonzero count");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(state_ff == ST_RWAIT))
      else $error("result raised without a read");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_busy)
      else $error("idle with updates still in flight");

endmodule
`default_nettype wire
